[sv/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic commit;
  } dp_cmd_t;

endpackage

[sv/lkvc_ctrl.sv]
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for the cache: accept, match, update, and the output valid flag.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lkvc_pkg::dp_cmd_t cmd
);

  lkvc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_tready  = (state_r == lkvc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = lkvc_pkg::ST_MATCH;
        end
      end
      lkvc_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkvc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/lkvc_dp.sv]
// ----------------------------------------------------------------------------
// lkvc_dp
// Entry storage, parallel key match, recency ranks and the result register.
// ----------------------------------------------------------------------------
module lkvc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lkvc_pkg::dp_cmd_t              cmd,
  input  logic                           cfg_wen,
  input  logic [lkvc_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic                           in_action,
  input  logic [lkvc_pkg::KEY_W-1:0]     in_key,
  input  logic [lkvc_pkg::VAL_W-1:0]     in_value,
  output logic                           out_found,
  output logic [lkvc_pkg::VAL_W-1:0]     out_read_value
);

  localparam int N  = lkvc_pkg::ENTRIES;
  localparam int IW = lkvc_pkg::IDX_W;
  localparam int CW = lkvc_pkg::CNT_W;
  localparam int MW = lkvc_pkg::CMP_W;

  logic [lkvc_pkg::KEY_W-1:0] key_r   [N];
  logic [lkvc_pkg::VAL_W-1:0] value_r [N];
  logic [IW-1:0]              rank_r  [N];
  logic [N-1:0]               valid_r;
  logic [CW-1:0]              occ_r;
  logic [lkvc_pkg::CAP_W-1:0] cap_r;

  logic                       act_r;
  logic [lkvc_pkg::KEY_W-1:0] req_key_r;
  logic [lkvc_pkg::VAL_W-1:0] req_val_r;

  logic                       hit_r, hit_nxt;
  logic [IW-1:0]              hit_idx_r, hit_idx_nxt;
  logic                       use_free_r, use_free_nxt;
  logic [IW-1:0]              free_idx_nxt, lru_idx_nxt;
  logic [IW-1:0]              slot_r, slot_nxt;

  logic [CW-1:0]              occ_m1;
  logic [MW-1:0]              cap_ext;
  logic [MW-1:0]              eff_cap;
  logic [IW-1:0]              touch_rank;
  logic                       do_touch;
  logic                       do_write;

  assign occ_m1  = occ_r - CW'(1);
  assign cap_ext = MW'(cap_r);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = MW'(1);
    end else if (cap_ext > MW'(N)) begin
      eff_cap = MW'(N);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    hit_nxt      = 1'b0;
    hit_idx_nxt  = '0;
    free_idx_nxt = '0;
    lru_idx_nxt  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == req_key_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = hit_idx_nxt | IW'(i);
      end
      if (!valid_r[i]) begin
        free_idx_nxt = IW'(i);
      end
      if (valid_r[i] && rank_r[i] == occ_m1[IW-1:0]) begin
        lru_idx_nxt = IW'(i);
      end
    end
    use_free_nxt = (MW'(occ_r) < eff_cap) && !(&valid_r);
    if (hit_nxt) begin
      slot_nxt = hit_idx_nxt;
    end else if (use_free_nxt) begin
      slot_nxt = free_idx_nxt;
    end else begin
      slot_nxt = lru_idx_nxt;
    end
  end

  assign touch_rank = rank_r[slot_r];
  assign do_touch   = cmd.commit && (hit_r || act_r == lkvc_pkg::ACT_SET);
  assign do_write   = cmd.commit && act_r == lkvc_pkg::ACT_SET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= lkvc_pkg::CAP_RESET;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      if (do_touch) begin
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == slot_r) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] &&
                       ((!hit_r && use_free_r) || rank_r[i] < touch_rank)) begin
            rank_r[i] <= rank_r[i] + IW'(1);
          end
        end
        if (!hit_r && use_free_r) begin
          valid_r[slot_r] <= 1'b1;
          occ_r           <= occ_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
    if (cmd.match) begin
      hit_r      <= hit_nxt;
      hit_idx_r  <= hit_idx_nxt;
      use_free_r <= use_free_nxt;
      slot_r     <= slot_nxt;
    end
    if (do_write) begin
      value_r[slot_r] <= req_val_r;
      if (!hit_r) begin
        key_r[slot_r] <= req_key_r;
      end
    end
    if (cmd.commit) begin
      out_found <= hit_r;
      if (act_r == lkvc_pkg::ACT_SET) begin
        out_read_value <= '0;
      end else if (hit_r) begin
        out_read_value <= value_r[hit_idx_r];
      end else begin
        out_read_value <= lkvc_pkg::MISS_VALUE;
      end
    end
  end

endmodule

[sv/lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
//
// Input channel in_*: one item is a get or a set with a key and a value.
// Output channel out_*: one result per item, found flag and read value.
// A get hit returns the stored value, a get miss returns all ones, and a
// set returns zero; found tells whether the key was present before.
// Configuration: cfg_wen writes cfg_wdata into the capacity register; it is
// meant to change only while no item is in flight.
// The request is registered when the item is accepted. The match step then
// registers the sixteen-way key match and the replacement choice, and the
// update step writes storage, ranks and the result register; it waits
// while an earlier result is still stalled. out_tvalid is set with the
// result. The sequencer handles one item at a time: in_tready is low from
// acceptance until the update step has written its result.
// The result register lets the next item enter while a result waits; if
// the receiver stalls, the following item holds in its update step.
// Reset empties the cache and sets capacity to the full entry count.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value [31:0]
  output logic        out_tuser   // found
);

  lkvc_pkg::dp_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lkvc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_tuser),
    .in_key         (in_tdata[31:0]),
    .in_value       (in_tdata[63:32]),
    .out_found      (out_tuser),
    .out_read_value (out_tdata)
  );

endmodule

[sv/lkvc_checker.sv]
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("Item accepted while the previous one is still in work.");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'h0 || out_tdata == 32'hFFFF_FFFF)
    else $error("Missing key returned neither zero nor all ones.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
